/* rtl/lgts_pkg.sv */
// Shared types, constants and the direction sine table of the light grid sampler.
package lgts_pkg;

  localparam int unsigned FRAC_BITS      = 8;
  localparam int unsigned POS_W          = 24;
  localparam int unsigned CI_W           = 9;
  localparam int unsigned BND_W          = 9;
  localparam int unsigned SCL_W          = 12;
  localparam int unsigned FAC_W          = FRAC_BITS + 1;
  localparam int unsigned FRAC_ONE       = 1 << FRAC_BITS;
  localparam int unsigned WEIGHT_BITS    = 3 * FRAC_BITS;
  localparam int unsigned W_W            = WEIGHT_BITS + 1;
  localparam int unsigned DIR_SHIFT      = (WEIGHT_BITS > 24) ? WEIGHT_BITS - 24 : 0;
  localparam int unsigned LIGHT_SHIFT    = 8;
  localparam int unsigned LS_W           = WEIGHT_BITS + 8;
  localparam int unsigned PC_W           = 30;
  localparam int unsigned DV_W           = W_W + PC_W;
  localparam int unsigned IDX_W          = 27;
  localparam int unsigned BB_W           = 18;
  localparam int unsigned MAG_W          = 30;
  localparam int unsigned UNIT_SHIFT     = 14;
  localparam int unsigned SINE_STEPS     = 256;
  localparam int unsigned QUARTER_TURN   = SINE_STEPS / 4;
  localparam int unsigned GRID_CELLS_DEF = 65536;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam logic [39:0] RENORM_LIM     = 40'(99) << WEIGHT_BITS;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

  typedef enum logic [2:0] {
    REG_BOUNDS_X   = 3'd0,
    REG_BOUNDS_Y   = 3'd1,
    REG_BOUNDS_Z   = 3'd2,
    REG_AMB_SCALE  = 3'd3,
    REG_DIR_SCALE  = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    BK_IDLE, BK_WGT, BK_MUL, BK_FETCH, BK_ACC, BK_DEN, BK_DIVL, BK_SCALE,
    BK_NORM, BK_SQR, BK_SUM, BK_ROOT, BK_DPREP, BK_DIVD, BK_OUT
  } back_state_e;

  typedef struct packed {
    logic              operation;
    logic [15:0]       cell_index;
    logic [63:0]       cell_data;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        ambient_r;
    logic [15:0]        ambient_g;
    logic [15:0]        ambient_b;
    logic [15:0]        directed_r;
    logic [15:0]        directed_g;
    logic [15:0]        directed_b;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } out_word_t;

  typedef struct packed {
    logic [BND_W-1:0] bx;
    logic [BND_W-1:0] by;
    logic [BND_W-1:0] bz;
  } bounds_t;

  typedef struct packed {
    logic [SCL_W-1:0] amb;
    logic [SCL_W-1:0] dir;
  } scale_t;

  typedef struct packed {
    logic                 is_query;
    logic [15:0]          cell_index;
    logic [63:0]          cell_data;
    logic [IDX_W-1:0]     base;
    logic [IDX_W-1:0]     cells;
    logic [BND_W-1:0]     bx;
    logic [BB_W-1:0]      bxby;
    logic [FRAC_BITS-1:0] frac_x;
    logic [FRAC_BITS-1:0] frac_y;
    logic [FRAC_BITS-1:0] frac_z;
  } q_entry_t;

  typedef logic signed [15:0] sine_tab_t [SINE_STEPS];

  function automatic logic signed [15:0] sine_step(input int unsigned b);
    logic [63:0] t, q, r, x, x2, term;
    logic signed [63:0] sm, v;
    int k;
    t = (64'(b % SINE_STEPS) << 32) / SINE_STEPS;
    q = t >> 30;
    r = t & 64'h3FFF_FFFF;
    if (q[0]) r = 64'h4000_0000 - r;
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sm = $signed(x);
    for (k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sm = sm - $signed(term);
      else sm = sm + $signed(term);
    end
    if (sm < 0) sm = 0;
    v = (sm + 64'sd32768) / 64'sd65536;
    if (v > 64'sd16384) v = 64'sd16384;
    return (q >= 64'd2) ? 16'(-v) : 16'(v);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    int i;
    for (i = 0; i < SINE_STEPS; i++) tab[i] = sine_step(i);
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

/* rtl/light_grid_trilinear_sampler.sv */
// Top level of the trilinear light grid sampler with its configuration registers.
// A write word loads one 64-bit grid cell; a query word returns one blended lighting word.
// The front part takes one word at a time, none more until the last is in the short queue
// to the back part. The back part retires a write word in its idle state; a query passes
// the weight, multiply, fetch and accumulate states for each of the eight corners on the
// single grid memory read port, a 16-step divider for the light channels, a shift loop
// to bring the direction under 2^30, a 32-step square root and a 15-step direction divider.
// A finished result waits in the output register while further words are accepted.
module light_grid_trilinear_sampler #(
  parameter int unsigned GRID_CELLS  = lgts_pkg::GRID_CELLS_DEF,
  parameter int unsigned QUEUE_DEPTH = lgts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lgts_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lgts_pkg::out_word_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  lgts_pkg::bounds_t  bounds_q;
  lgts_pkg::scale_t   scale_q;
  lgts_pkg::q_entry_t push_ent, pop_ent;
  logic               push, full, pop, empty, cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q.bx <= lgts_pkg::BND_W'(1);
      bounds_q.by <= lgts_pkg::BND_W'(1);
      bounds_q.bz <= lgts_pkg::BND_W'(1);
      scale_q.amb <= lgts_pkg::SCL_W'(256);
      scale_q.dir <= lgts_pkg::SCL_W'(256);
    end else if (cfg_we) begin
      case (lgts_pkg::reg_idx_e'(paddr[4:2]))
        lgts_pkg::REG_BOUNDS_X:  bounds_q.bx <= pwdata[lgts_pkg::BND_W-1:0];
        lgts_pkg::REG_BOUNDS_Y:  bounds_q.by <= pwdata[lgts_pkg::BND_W-1:0];
        lgts_pkg::REG_BOUNDS_Z:  bounds_q.bz <= pwdata[lgts_pkg::BND_W-1:0];
        lgts_pkg::REG_AMB_SCALE: scale_q.amb <= pwdata[lgts_pkg::SCL_W-1:0];
        lgts_pkg::REG_DIR_SCALE: scale_q.dir <= pwdata[lgts_pkg::SCL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (lgts_pkg::reg_idx_e'(paddr[4:2]))
      lgts_pkg::REG_BOUNDS_X:  prdata = 32'(bounds_q.bx);
      lgts_pkg::REG_BOUNDS_Y:  prdata = 32'(bounds_q.by);
      lgts_pkg::REG_BOUNDS_Z:  prdata = 32'(bounds_q.bz);
      lgts_pkg::REG_AMB_SCALE: prdata = 32'(scale_q.amb);
      lgts_pkg::REG_DIR_SCALE: prdata = 32'(scale_q.dir);
      default:                 prdata = '0;
    endcase
  end

  lgts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .bounds_i   (bounds_q),
    .push_o     (push),
    .entry_o    (push_ent),
    .full_i     (full)
  );

  lgts_fifo #(
    .DATA_W ($bits(lgts_pkg::q_entry_t)),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_ent),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_ent),
    .empty_o (empty)
  );

  lgts_back #(
    .GRID_CELLS (GRID_CELLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_i       (pop_ent),
    .ent_valid_i (!empty),
    .ent_pop_o   (pop),
    .scale_i     (scale_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/lgts_fifo.sv */
// Short queue of decoded words between the front and back parts.
module lgts_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + CNT_W'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= data_i;
  end

endmodule

/* rtl/lgts_front.sv */
// Front part: takes input words, splits and clamps the position and forms the base cell index.
module lgts_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lgts_pkg::in_word_t in_data_i,
  input  lgts_pkg::bounds_t  bounds_i,
  output logic               push_o,
  output lgts_pkg::q_entry_t entry_o,
  input  logic               full_i
);

  localparam int unsigned CM_W = lgts_pkg::POS_W - lgts_pkg::FRAC_BITS - 1;

  typedef struct packed {
    logic [lgts_pkg::CI_W-1:0]      cidx;
    logic [lgts_pkg::FRAC_BITS-1:0] frac;
  } axis_t;

  function automatic logic [lgts_pkg::BND_W-1:0] eff_bound(
    input logic [lgts_pkg::BND_W-1:0] bnd);
    return (bnd == '0) ? lgts_pkg::BND_W'(1) : bnd;
  endfunction

  function automatic axis_t split_axis(input logic signed [lgts_pkg::POS_W-1:0] pos,
                                       input logic [lgts_pkg::BND_W-1:0] bnd);
    logic [lgts_pkg::BND_W-1:0] bm1;
    logic [CM_W-1:0]            c_mag;
    axis_t                      a;
    bm1   = eff_bound(bnd) - lgts_pkg::BND_W'(1);
    c_mag = pos[lgts_pkg::POS_W-2:lgts_pkg::FRAC_BITS];
    if (pos[lgts_pkg::POS_W-1]) begin
      a = '0;
    end else if (c_mag >= CM_W'(bm1)) begin
      a.cidx = bm1[lgts_pkg::CI_W-1:0];
      a.frac = '0;
    end else begin
      a.cidx = c_mag[lgts_pkg::CI_W-1:0];
      a.frac = pos[lgts_pkg::FRAC_BITS-1:0];
    end
    return a;
  endfunction

  lgts_pkg::in_word_t            item_q;
  logic                          busy_q;
  logic [1:0]                    st_q;
  axis_t                         ax_q, ay_q, az_q, ax_d, ay_d, az_d;
  logic [lgts_pkg::BND_W-1:0]    bx_q;
  logic [lgts_pkg::BB_W-1:0]     bxby_q, c1bx_q;
  logic [lgts_pkg::IDX_W-1:0]    c2bb_q, cells_q;
  logic [lgts_pkg::BND_W-1:0]    bx_e, by_e, bz_e;
  logic                          accept;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign push_o     = busy_q && (st_q == 2'd3) && !full_i;
  assign bx_e       = eff_bound(bounds_i.bx);
  assign by_e       = eff_bound(bounds_i.by);
  assign bz_e       = eff_bound(bounds_i.bz);
  assign ax_d       = split_axis(item_q.pos_x, bounds_i.bx);
  assign ay_d       = split_axis(item_q.pos_y, bounds_i.by);
  assign az_d       = split_axis(item_q.pos_z, bounds_i.bz);

  always_comb begin
    entry_o            = '0;
    entry_o.is_query   = item_q.operation;
    entry_o.cell_index = item_q.cell_index;
    entry_o.cell_data  = item_q.cell_data;
    entry_o.base       = lgts_pkg::IDX_W'(ax_q.cidx) + lgts_pkg::IDX_W'(c1bx_q) + c2bb_q;
    entry_o.cells      = cells_q;
    entry_o.bx         = bx_q;
    entry_o.bxby       = bxby_q;
    entry_o.frac_x     = ax_q.frac;
    entry_o.frac_y     = ay_q.frac;
    entry_o.frac_z     = az_q.frac;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      st_q   <= 2'd0;
    end else if (accept) begin
      busy_q <= 1'b1;
      st_q   <= 2'd0;
    end else if (push_o) begin
      busy_q <= 1'b0;
    end else if (busy_q && st_q != 2'd3) begin
      st_q <= st_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (busy_q) begin
      case (st_q)
        2'd0: begin
          ax_q   <= ax_d;
          ay_q   <= ay_d;
          az_q   <= az_d;
          bx_q   <= bx_e;
          bxby_q <= lgts_pkg::BB_W'(bx_e * by_e);
        end
        2'd1: c1bx_q <= lgts_pkg::BB_W'(ay_q.cidx * bx_q);
        2'd2: begin
          c2bb_q  <= lgts_pkg::IDX_W'(az_q.cidx * bxby_q);
          cells_q <= lgts_pkg::IDX_W'(bxby_q * bz_e);
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/lgts_back.sv */
// Back part: grid memory, corner accumulation, renormalisation and direction normalisation.
module lgts_back #(
  parameter int unsigned GRID_CELLS = lgts_pkg::GRID_CELLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lgts_pkg::q_entry_t  ent_i,
  input  logic                ent_valid_i,
  output logic                ent_pop_o,
  input  lgts_pkg::scale_t    scale_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lgts_pkg::out_word_t out_data_o
);

  localparam int unsigned ADDR_W = $clog2(GRID_CELLS);
  localparam int unsigned W_W    = lgts_pkg::W_W;
  localparam int unsigned LS_W   = lgts_pkg::LS_W;
  localparam int unsigned DV_W   = lgts_pkg::DV_W;
  localparam int unsigned PC_W   = lgts_pkg::PC_W;
  localparam int unsigned FAC_W  = lgts_pkg::FAC_W;
  localparam int unsigned MAG_W  = lgts_pkg::MAG_W;
  localparam int unsigned LSH    = lgts_pkg::LIGHT_SHIFT;
  localparam int unsigned USH    = lgts_pkg::UNIT_SHIFT;
  localparam int unsigned WD_W   = W_W - lgts_pkg::DIR_SHIFT;

  logic [63:0] grid_q [GRID_CELLS];

  lgts_pkg::back_state_e state_q, state_d;
  lgts_pkg::q_entry_t    ent_q;
  logic [2:0]            corner_q;
  logic [4:0]            cnt_q;
  logic [2*FAC_W-1:0]    p1_q;
  logic [lgts_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [W_W-1:0]        w_q, total_q, den_q;
  logic                  ok_q, use_q;
  logic [63:0]           rd_q;
  logic signed [PC_W-1:0] pcx_q, pcy_q, pcz_q, pcx_d, pcy_d;
  logic [LS_W-1:0]       lsum_q [6];
  logic signed [DV_W-1:0] dv_q [3];
  logic signed [DV_W-1:0] pd [3];
  logic [W_W-1:0]        rem_q [6];
  logic [15:0]           low_q [6];
  logic [15:0]           quo_q [6];
  logic [W_W:0]          ltrial [6];
  logic                  lge [6];
  logic [15:0]           light_q [6];
  logic [DV_W-1:0]       mag_q [3];
  logic                  neg_q [3];
  logic [2*MAG_W-1:0]    sq_q [3];
  logic [63:0]           s_q, res_q, bit_q, rb;
  logic [31:0]           len_q;
  logic [31:0]           drem_q [3];
  logic [USH:0]          dlow_q [3];
  logic [USH:0]          dquo_q [3];
  logic [32:0]           dtrial [3];
  logic                  dge [3];
  logic [FAC_W-1:0]      fa, fb, fc;
  logic [WD_W-1:0]       wd;
  logic signed [15:0]    sg, cg, sl, cl;
  logic                  big, renorm, mem_we, out_load, out_valid_q;
  lgts_pkg::out_word_t   out_q;
  logic [27:0]           sprod [6];

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign fa = corner_q[0] ? FAC_W'(ent_q.frac_x) : FAC_W'(lgts_pkg::FRAC_ONE) - FAC_W'(ent_q.frac_x);
  assign fb = corner_q[1] ? FAC_W'(ent_q.frac_y) : FAC_W'(lgts_pkg::FRAC_ONE) - FAC_W'(ent_q.frac_y);
  assign fc = corner_q[2] ? FAC_W'(ent_q.frac_z) : FAC_W'(lgts_pkg::FRAC_ONE) - FAC_W'(ent_q.frac_z);
  assign idx_d = ent_q.base + (corner_q[0] ? lgts_pkg::IDX_W'(1) : '0)
               + (corner_q[1] ? lgts_pkg::IDX_W'(ent_q.bx) : '0)
               + (corner_q[2] ? lgts_pkg::IDX_W'(ent_q.bxby) : '0);

  assign sg = lgts_pkg::SINE_TAB[rd_q[55:48]];
  assign cg = lgts_pkg::SINE_TAB[8'(rd_q[55:48] + 8'(lgts_pkg::QUARTER_TURN))];
  assign sl = lgts_pkg::SINE_TAB[rd_q[63:56]];
  assign cl = lgts_pkg::SINE_TAB[8'(rd_q[63:56] + 8'(lgts_pkg::QUARTER_TURN))];
  assign pcx_d = cl * sg;
  assign pcy_d = sl * sg;

  assign wd    = w_q[W_W-1:lgts_pkg::DIR_SHIFT];
  assign pd[0] = $signed({1'b0, wd}) * pcx_q;
  assign pd[1] = $signed({1'b0, wd}) * pcy_q;
  assign pd[2] = $signed({1'b0, wd}) * pcz_q;

  assign renorm = (total_q != '0) && ((40'(total_q) * 40'd100) < lgts_pkg::RENORM_LIM);
  assign big    = (mag_q[0][DV_W-1:MAG_W] != '0) || (mag_q[1][DV_W-1:MAG_W] != '0)
               || (mag_q[2][DV_W-1:MAG_W] != '0);
  assign rb     = res_q + bit_q;

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      ltrial[j] = {rem_q[j], low_q[j][15]};
      lge[j]    = ltrial[j] >= {1'b0, den_q};
      sprod[j]  = quo_q[j] * ((j < 3) ? scale_i.amb : scale_i.dir);
    end
    for (int j = 0; j < 3; j++) begin
      dtrial[j] = {drem_q[j], dlow_q[j][USH]};
      dge[j]    = dtrial[j] >= {1'b0, len_q};
    end
  end

  always_comb begin
    ent_pop_o = (state_q == lgts_pkg::BK_IDLE) && ent_valid_i;
    mem_we    = ent_pop_o && !ent_i.is_query && (32'(ent_i.cell_index) < 32'(GRID_CELLS));
    out_load  = (state_q == lgts_pkg::BK_OUT) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lgts_pkg::BK_IDLE:  if (ent_valid_i && ent_i.is_query) state_d = lgts_pkg::BK_WGT;
      lgts_pkg::BK_WGT:   state_d = lgts_pkg::BK_MUL;
      lgts_pkg::BK_MUL:   state_d = lgts_pkg::BK_FETCH;
      lgts_pkg::BK_FETCH: state_d = lgts_pkg::BK_ACC;
      lgts_pkg::BK_ACC:   state_d = (corner_q == 3'd7) ? lgts_pkg::BK_DEN : lgts_pkg::BK_WGT;
      lgts_pkg::BK_DEN:   state_d = lgts_pkg::BK_DIVL;
      lgts_pkg::BK_DIVL:  if (cnt_q == 5'd15) state_d = lgts_pkg::BK_SCALE;
      lgts_pkg::BK_SCALE: state_d = lgts_pkg::BK_NORM;
      lgts_pkg::BK_NORM:  if (!big) state_d = lgts_pkg::BK_SQR;
      lgts_pkg::BK_SQR:   state_d = lgts_pkg::BK_SUM;
      lgts_pkg::BK_SUM:   state_d = lgts_pkg::BK_ROOT;
      lgts_pkg::BK_ROOT:  if (cnt_q == 5'd31) state_d = lgts_pkg::BK_DPREP;
      lgts_pkg::BK_DPREP: state_d = lgts_pkg::BK_DIVD;
      lgts_pkg::BK_DIVD:  if (cnt_q == 5'(USH)) state_d = lgts_pkg::BK_OUT;
      lgts_pkg::BK_OUT:   if (out_load) state_d = lgts_pkg::BK_IDLE;
      default:            state_d = lgts_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgts_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) grid_q[ADDR_W'(ent_i.cell_index)] <= ent_i.cell_data;
    if (state_q == lgts_pkg::BK_MUL) rd_q <= grid_q[ADDR_W'(idx_q)];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lgts_pkg::BK_IDLE: begin
        ent_q    <= ent_i;
        corner_q <= 3'd0;
        total_q  <= '0;
        for (int j = 0; j < 6; j++) lsum_q[j] <= '0;
        for (int j = 0; j < 3; j++) dv_q[j] <= '0;
      end
      lgts_pkg::BK_WGT: begin
        p1_q  <= fa * fb;
        idx_q <= idx_d;
      end
      lgts_pkg::BK_MUL: begin
        w_q  <= W_W'(p1_q * fc);
        ok_q <= (fa != '0) && (fb != '0) && (fc != '0) && (idx_q < ent_q.cells)
                && (32'(idx_q) < 32'(GRID_CELLS));
      end
      lgts_pkg::BK_FETCH: begin
        use_q <= ok_q && (rd_q[23:0] != 24'd0);
        pcx_q <= pcx_d;
        pcy_q <= pcy_d;
        pcz_q <= PC_W'(cg) <<< USH;
      end
      lgts_pkg::BK_ACC: begin
        corner_q <= corner_q + 3'd1;
        if (use_q) begin
          total_q <= total_q + w_q;
          for (int j = 0; j < 6; j++) lsum_q[j] <= lsum_q[j] + LS_W'(w_q * rd_q[8*j +: 8]);
          for (int j = 0; j < 3; j++) dv_q[j] <= dv_q[j] + pd[j];
        end
      end
      lgts_pkg::BK_DEN: begin
        den_q <= renorm ? total_q : W_W'(1) << lgts_pkg::WEIGHT_BITS;
        cnt_q <= '0;
        for (int j = 0; j < 6; j++) begin
          rem_q[j] <= W_W'(lsum_q[j][LS_W-1:LSH]);
          low_q[j] <= {lsum_q[j][LSH-1:0], 8'd0};
          quo_q[j] <= '0;
        end
      end
      lgts_pkg::BK_DIVL: begin
        cnt_q <= cnt_q + 5'd1;
        for (int j = 0; j < 6; j++) begin
          rem_q[j] <= lge[j] ? W_W'(ltrial[j] - {1'b0, den_q}) : W_W'(ltrial[j]);
          quo_q[j] <= {quo_q[j][14:0], lge[j]};
          low_q[j] <= {low_q[j][14:0], 1'b0};
        end
      end
      lgts_pkg::BK_SCALE: begin
        for (int j = 0; j < 6; j++) begin
          light_q[j] <= (sprod[j][27:24] != 4'd0) ? 16'hFFFF : sprod[j][23:8];
        end
        for (int j = 0; j < 3; j++) begin
          neg_q[j] <= dv_q[j][DV_W-1];
          mag_q[j] <= dv_q[j][DV_W-1] ? DV_W'(-dv_q[j]) : DV_W'(dv_q[j]);
        end
      end
      lgts_pkg::BK_NORM: begin
        if (big) for (int j = 0; j < 3; j++) mag_q[j] <= mag_q[j] >> 1;
      end
      lgts_pkg::BK_SQR: begin
        for (int j = 0; j < 3; j++) sq_q[j] <= mag_q[j][MAG_W-1:0] * mag_q[j][MAG_W-1:0];
      end
      lgts_pkg::BK_SUM: begin
        s_q   <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
        res_q <= '0;
        bit_q <= 64'd1 << 62;
        cnt_q <= '0;
      end
      lgts_pkg::BK_ROOT: begin
        cnt_q <= cnt_q + 5'd1;
        bit_q <= bit_q >> 2;
        if (s_q >= rb) begin
          s_q   <= s_q - rb;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
      end
      lgts_pkg::BK_DPREP: begin
        len_q <= res_q[31:0];
        cnt_q <= '0;
        for (int j = 0; j < 3; j++) begin
          drem_q[j] <= 32'(mag_q[j][MAG_W-1:1]);
          dlow_q[j] <= {mag_q[j][0], USH'(0)};
          dquo_q[j] <= '0;
        end
      end
      lgts_pkg::BK_DIVD: begin
        cnt_q <= cnt_q + 5'd1;
        for (int j = 0; j < 3; j++) begin
          drem_q[j] <= dge[j] ? 32'(dtrial[j] - {1'b0, len_q}) : 32'(dtrial[j]);
          dquo_q[j] <= {dquo_q[j][USH-1:0], dge[j]};
          dlow_q[j] <= {dlow_q[j][USH-1:0], 1'b0};
        end
      end
      lgts_pkg::BK_OUT: begin
        if (out_load) begin
          out_q.ambient_r  <= light_q[0];
          out_q.ambient_g  <= light_q[1];
          out_q.ambient_b  <= light_q[2];
          out_q.directed_r <= light_q[3];
          out_q.directed_g <= light_q[4];
          out_q.directed_b <= light_q[5];
          out_q.dir_x <= (len_q == '0) ? '0 : neg_q[0] ? -16'(dquo_q[0]) : 16'(dquo_q[0]);
          out_q.dir_y <= (len_q == '0) ? '0 : neg_q[1] ? -16'(dquo_q[1]) : 16'(dquo_q[1]);
          out_q.dir_z <= (len_q == '0) ? '0 : neg_q[2] ? -16'(dquo_q[2]) : 16'(dquo_q[2]);
        end
      end
      default: ;
    endcase
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the trilinear light grid sampler: random and directed words, scoreboard check.
`timescale 1ns / 100ps

class light_sampler_sb;
  logic [63:0] grid [65536];
  int unsigned bx, by, bz, amb_gain, dir_gain;
  lgts_pkg::out_word_t lighting_q[$];
  int errors;

  function new();
    bx = 1;
    by = 1;
    bz = 1;
    amb_gain = 256;
    dir_gain = 256;
    errors = 0;
  endfunction

  function longint sine_q14(longint unsigned ph);
    longint unsigned t, q, r, x, x2, term;
    longint sm, v;
    ph = ph % 1024;
    t = (ph << 32) / 1024;
    q = t >> 30;
    r = t & 64'h3FFF_FFFF;
    if (q[0]) r = 64'h4000_0000 - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sm = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sm = sm - longint'(term);
      else sm = sm + longint'(term);
    end
    if (sm < 0) sm = 0;
    v = (sm + 32768) / 65536;
    if (v > 16384) v = 16384;
    return (q >= 2) ? -v : v;
  endfunction

  function longint unsigned root_floor(longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Corner cell numbers and weights; a weight of zero marks a corner that takes no part.
  function void corners(lgts_pkg::in_word_t q, output longint unsigned idx[8],
                        output longint unsigned w[8]);
    longint cpos[3];
    longint unsigned frac[3], cc[3], cells, wt, ix;
    longint v, b;
    int unsigned bnd[3];
    logic signed [23:0] p[3];
    bnd[0] = bx ? bx : 1;
    bnd[1] = by ? by : 1;
    bnd[2] = bz ? bz : 1;
    p[0] = q.pos_x;
    p[1] = q.pos_y;
    p[2] = q.pos_z;
    cells = longint'(bnd[0]) * bnd[1] * bnd[2];
    for (int j = 0; j < 3; j++) begin
      v = longint'(p[j]);
      frac[j] = v & 255;
      cpos[j] = v >>> 8;
      b = bnd[j];
      if (cpos[j] < 0) begin
        cpos[j] = 0;
        frac[j] = 0;
      end else if (cpos[j] >= b - 1) begin
        cpos[j] = b - 1;
        frac[j] = 0;
      end
    end
    for (int i = 0; i < 8; i++) begin
      wt = 1;
      for (int j = 0; j < 3; j++) begin
        cc[j] = cpos[j];
        if ((i >> j) & 1) begin
          wt = wt * frac[j];
          cc[j] = cc[j] + 1;
        end else begin
          wt = wt * (256 - frac[j]);
        end
      end
      ix = cc[0] + cc[1] * bnd[0] + cc[2] * bnd[0] * bnd[1];
      if (ix >= cells || ix >= 65536) wt = 0;
      idx[i] = ix;
      w[i] = wt;
    end
  endfunction

  function logic [15:0] light(longint unsigned sum, longint unsigned den, int unsigned g);
    longint unsigned n, o;
    n = (sum << 8) / den;
    o = (n * g) >> 8;
    return (o > 65535) ? 16'hFFFF : o[15:0];
  endfunction

  function lgts_pkg::out_word_t predict(lgts_pkg::in_word_t q);
    longint unsigned idx[8], w[8];
    longint unsigned amb[3], dl[3], mag[3], total, den, maxm, s, len, o, d, lng, lat;
    longint dv[3], sl, cl, sg, cg, wd;
    int k;
    logic [15:0] dir[3];
    lgts_pkg::out_word_t r;
    corners(q, idx, w);
    total = 0;
    for (int j = 0; j < 3; j++) begin
      amb[j] = 0;
      dl[j] = 0;
      dv[j] = 0;
    end
    for (int i = 0; i < 8; i++) begin
      if (w[i] == 0) continue;
      d = grid[idx[i]];
      if ((64'(d[7:0]) + 64'(d[15:8]) + 64'(d[23:16])) == 0) continue;
      total += w[i];
      for (int j = 0; j < 3; j++) begin
        amb[j] += w[i] * ((d >> (8 * j)) & 255);
        dl[j] += w[i] * ((d >> (24 + 8 * j)) & 255);
      end
      lng = ((d >> 48) & 255) * 4;
      lat = ((d >> 56) & 255) * 4;
      sl = sine_q14(lat);
      cl = sine_q14(lat + 256);
      sg = sine_q14(lng);
      cg = sine_q14(lng + 256);
      wd = longint'(w[i] >> lgts_pkg::DIR_SHIFT);
      dv[0] += wd * (cl * sg);
      dv[1] += wd * (sl * sg);
      dv[2] += wd * (cg * 16384);
    end
    den = 64'd1 << 24;
    if (total > 0 && total * 100 < 99 * den) den = total;
    r.ambient_r = light(amb[0], den, amb_gain);
    r.ambient_g = light(amb[1], den, amb_gain);
    r.ambient_b = light(amb[2], den, amb_gain);
    r.directed_r = light(dl[0], den, dir_gain);
    r.directed_g = light(dl[1], den, dir_gain);
    r.directed_b = light(dl[2], den, dir_gain);
    maxm = 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] = (dv[j] < 0) ? longint'(-dv[j]) : longint'(dv[j]);
      if (mag[j] > maxm) maxm = mag[j];
    end
    k = 0;
    while ((maxm >> k) >= (64'd1 << 30)) k++;
    s = 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] = mag[j] >> k;
      s += mag[j] * mag[j];
    end
    len = root_floor(s);
    for (int j = 0; j < 3; j++) begin
      o = len ? (mag[j] * 16384) / len : 0;
      dir[j] = (dv[j] < 0) ? 16'(0 - o) : 16'(o);
    end
    r.dir_x = dir[0];
    r.dir_y = dir[1];
    r.dir_z = dir[2];
    return r;
  endfunction

  function void note_word(lgts_pkg::in_word_t d);
    if (!d.operation) grid[d.cell_index] = d.cell_data;
    else lighting_q.push_back(predict(d));
  endfunction

  function void cmp(string nm, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, e, a);
      errors++;
    end
  endfunction

  function void check_word(lgts_pkg::out_word_t a);
    lgts_pkg::out_word_t e;
    if (lighting_q.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual %h", $time, a);
      errors++;
      return;
    end
    e = lighting_q.pop_front();
    cmp("ambient_r", e.ambient_r, a.ambient_r);
    cmp("ambient_g", e.ambient_g, a.ambient_g);
    cmp("ambient_b", e.ambient_b, a.ambient_b);
    cmp("directed_r", e.directed_r, a.directed_r);
    cmp("directed_g", e.directed_g, a.directed_g);
    cmp("directed_b", e.directed_b, a.directed_b);
    cmp("dir_x", e.dir_x, a.dir_x);
    cmp("dir_y", e.dir_y, a.dir_y);
    cmp("dir_z", e.dir_z, a.dir_z);
  endfunction

  function int pending();
    return lighting_q.size();
  endfunction
endclass

module tb_top;
  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  lgts_pkg::in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  lgts_pkg::out_word_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  light_sampler_sb sb = new();
  bit seeded [65536];
  int idle_in = 29;
  int idle_out = 73;
  int hold_req = 0;
  int hold_cnt = 0;
  int n_sent = 0;
  longint cycles = 0;

  light_grid_trilinear_sampler u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_data_o);
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_out);
    end
  end

  task automatic send(lgts_pkg::in_word_t w);
    while ($urandom_range(99) < idle_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    n_sent++;
  endtask

  task automatic write_cell(logic [15:0] idx, logic [63:0] data);
    lgts_pkg::in_word_t w;
    w = '0;
    w.operation = OP_WRITE;
    w.cell_index = idx;
    w.cell_data = data;
    seeded[idx] = 1'b1;
    send(w);
  endtask

  function automatic logic [63:0] rand_cell();
    logic [63:0] d;
    d = {$urandom, $urandom};
    if ($urandom_range(5) == 0) d[23:0] = '0;
    return d;
  endfunction

  // Every corner with a nonzero weight that was never written gets written before the query.
  task automatic query(int px, int py, int pz);
    lgts_pkg::in_word_t w;
    longint unsigned idx[8], wt[8];
    w = '0;
    w.operation = OP_QUERY;
    w.pos_x = 24'(px);
    w.pos_y = 24'(py);
    w.pos_z = 24'(pz);
    w.cell_index = 16'($urandom);
    w.cell_data = {$urandom, $urandom};
    sb.corners(w, idx, wt);
    for (int i = 0; i < 8; i++)
      if (wt[i] != 0 && !seeded[idx[i]]) write_cell(16'(idx[i]), rand_cell());
    send(w);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(int unsigned x, int unsigned y, int unsigned z,
                           int unsigned ag, int unsigned dg);
    reg_write(lgts_pkg::REG_BOUNDS_X, x);
    reg_write(lgts_pkg::REG_BOUNDS_Y, y);
    reg_write(lgts_pkg::REG_BOUNDS_Z, z);
    reg_write(lgts_pkg::REG_AMB_SCALE, ag);
    reg_write(lgts_pkg::REG_DIR_SCALE, dg);
    sb.bx = x & 9'h1FF;
    sb.by = y & 9'h1FF;
    sb.bz = z & 9'h1FF;
    sb.amb_gain = ag & 12'hFFF;
    sb.dir_gain = dg & 12'hFFF;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic int rand_axis(int unsigned b);
    int p;
    if (b == 0) b = 1;
    if ($urandom_range(9) < 7) p = int'($urandom_range(0, (b + 1) * 256)) - 256;
    else p = int'({{8{1'b0}}, 24'($urandom)}) - 32'sh800000;
    if ($urandom_range(4) == 0) p = p & ~255;
    return p;
  endfunction

  // Sends about n words, the corner writes that queries need included.
  task automatic random_items(int n);
    longint unsigned cells;
    int start;
    start = n_sent;
    while (n_sent - start < n) begin
      cells = longint'(sb.bx ? sb.bx : 1) * (sb.by ? sb.by : 1) * (sb.bz ? sb.bz : 1);
      if (cells > 65536) cells = 65536;
      if ($urandom_range(9) < 7) begin
        query(rand_axis(sb.bx), rand_axis(sb.by), rand_axis(sb.bz));
      end else if ($urandom_range(3) == 0) begin
        write_cell(16'($urandom), rand_cell());
      end else begin
        write_cell(16'($urandom_range(0, 32'(cells - 1))), rand_cell());
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(4, 3, 2, 256, 256);
    write_cell(0, 64'h0000_00FF_FFFF_FFFF);
    write_cell(1, 64'h40C0_0080_8080_0000);
    write_cell(2, 64'h0000_2030_4010_2030);
    write_cell(3, 64'h0080_2030_4010_2030);
    query(128, 0, 0);
    query(256, 0, 0);
    query(2 * 256 + 128, 0, 0);
    query(0, 0, 0);
    query(-300, -1, -8388608);
    query(8388607, 8388607, 8388607);
    query(255, 255, 255);
    query(1, 1, 1);
    query(3 * 256, 2 * 256, 256);
    query(2 * 256 + 255, 256 + 128, 64);
    query(700, 100, 200);
    random_items(250);
    drain();

    configure(1, 1, 1, 0, 4095);
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    random_items(150);
    drain();

    idle_in = 73;
    idle_out = 29;
    configure(256, 256, 256, 4095, 0);
    random_items(250);
    drain();
    configure(0, 7, 0, 1000, 300);
    random_items(250);
    drain();

    idle_in = 0;
    idle_out = 0;
    configure(511, 2, 3, 4095, 4095);
    random_items(250);
    drain();
    configure(16, 16, 8, 256, 256);
    hold_req = 800;
    random_items(400);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
